### design/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// No dependencies; every other design file imports this package.
package stq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TARGET_BITS_DEF = 8;
	localparam int TIME_W          = 48;
	localparam int WORD_W          = 32;
	localparam int ID_W            = 8;

	// Opcodes of an input item
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_REQUEST  = 2'd1;
	localparam logic [1:0] OP_KILL     = 2'd2;
	localparam logic [1:0] OP_KILL_ALL = 2'd3;

	// Input item
	typedef struct packed {
		logic [1:0]        opcode;
		logic [ID_W-1:0]   target_id;
		logic [WORD_W-1:0] timeout_ticks;
		logic [WORD_W-1:0] cookie;
	} req_t;

	// Result item
	typedef struct packed {
		logic              fired;
		logic [ID_W-1:0]   fired_target;
		logic [WORD_W-1:0] fired_cookie;
		logic [WORD_W-1:0] time_to_next;
		logic              dropped_full;
		logic              last;
	} rsp_t;

	// One table entry, less its target
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] due;
		logic [WORD_W-1:0] cookie;
	} entry_t;

	// What every cell does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_MARK   = 3'd2,
		CELL_SHIFT  = 3'd3,
		CELL_POP    = 3'd4
	} cell_op_t;

	// Command broadcast along the chain
	typedef struct packed {
		cell_op_t          op;
		logic              match_all;
		logic [TIME_W-1:0] due;
		logic [WORD_W-1:0] cookie;
	} cell_cmd_t;

endpackage

### design/sorted_timer_queue_unit.sv
// Sorted timer queue: a chain of entry cells kept in due-time order, plus its sequencer.
// Top level; depends on stq_pkg and stq_cell.
//
// The table is a row of QUEUE_DEPTH cells, each holding one timer, kept sorted by due time and
// packed towards the head. A request forms its due time on acceptance; then every cell decides
// in one step whether to keep, take the new entry or take its left neighbour's. A kill or
// kill-all first marks the matching entries, then compacts the table step by step; each
// step moves everything behind the first empty cell one place towards the head, so it needs at
// most QUEUE_DEPTH steps. A tick pops expired timers off the head one entry at a time, giving a
// result for each, or a single result when nothing expires. One item is in work at a time;
// the result register lets the next item in while the last result waits to be taken.
module sorted_timer_queue_unit import stq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TARGET_BITS = TARGET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INS  = 7'b0000010,
		S_MARK = 7'b0000100,
		S_PACK = 7'b0001000,
		S_HEAD = 7'b0010000,
		S_FIRE = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [TIME_W-1:0]      time_q;
	logic                   drop_q;
	logic [1:0]             op_q;
	logic [TARGET_BITS-1:0] tgt_q;
	logic [WORD_W-1:0]      ck_q;
	logic [TIME_W-1:0]      due_q;
	logic [TARGET_BITS-1:0] fire_tgt_q;
	logic [WORD_W-1:0]      fire_ck_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	cell_cmd_t              cmd;
	entry_t                 cell_ent [QUEUE_DEPTH];
	logic [TARGET_BITS-1:0] cell_tgt [QUEUE_DEPTH];
	logic                   cell_keep [QUEUE_DEPTH];
	logic                   cell_hole [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_vec;
	logic [QUEUE_DEPTH-1:0] gap_vec;

	logic                   accept;
	logic                   full;
	logic                   any_gap;
	logic                   head_ready;
	logic [TIME_W-1:0]      head_diff;
	logic [WORD_W-1:0]      ttn;
	logic                   out_free;
	logic                   load_rsp;
	rsp_t                   rsp_d;

	// Chain of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t                 lent;
		entry_t                 rent;
		logic [TARGET_BITS-1:0] ltgt;
		logic [TARGET_BITS-1:0] rtgt;
		logic                   lkeep;
		logic                   lhole;
		logic                   cgap;

		if (i == 0) begin : g_first
			assign lent  = '0;
			assign ltgt  = '0;
			assign lkeep = 1'b1;
			assign lhole = 1'b0;
		end else begin : g_mid
			assign lent  = cell_ent[i-1];
			assign ltgt  = cell_tgt[i-1];
			assign lkeep = cell_keep[i-1];
			assign lhole = cell_hole[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rent = '0;
			assign rtgt = '0;
		end else begin : g_inner
			assign rent = cell_ent[i+1];
			assign rtgt = cell_tgt[i+1];
		end

		stq_cell #(.TARGET_BITS(TARGET_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.cmd_tgt   (tgt_q),
			.left_ent  (lent),
			.left_tgt  (ltgt),
			.left_keep (lkeep),
			.left_hole (lhole),
			.right_ent (rent),
			.right_tgt (rtgt),
			.ent       (cell_ent[i]),
			.tgt       (cell_tgt[i]),
			.keep      (cell_keep[i]),
			.hole      (cell_hole[i]),
			.gap       (cgap)
		);

		assign valid_vec[i] = cell_ent[i].valid;
		assign gap_vec[i]   = cgap;
	end

	assign full    = valid_vec[QUEUE_DEPTH-1];
	assign any_gap = |gap_vec;

	// Head status and distance to the head entry
	always_comb begin
		head_ready = cell_ent[0].valid && (cell_ent[0].due <= time_q);
		head_diff  = cell_ent[0].due - time_q;
		if (!cell_ent[0].valid) begin
			ttn = '1;
		end else if (cell_ent[0].due <= time_q) begin
			ttn = '0;
		end else if (|head_diff[TIME_W-1:WORD_W]) begin
			ttn = '1;
		end else begin
			ttn = head_diff[WORD_W-1:0];
		end
	end

	// Command to the chain
	always_comb begin
		cmd.op        = CELL_HOLD;
		cmd.match_all = (op_q == OP_KILL_ALL);
		cmd.due       = due_q;
		cmd.cookie    = ck_q;
		unique case (state_q)
			S_INS:   cmd.op = full ? CELL_HOLD : CELL_INSERT;
			S_MARK:  cmd.op = CELL_MARK;
			S_PACK:  cmd.op = any_gap ? CELL_SHIFT : CELL_HOLD;
			S_HEAD:  cmd.op = head_ready ? CELL_POP : CELL_HOLD;
			default: cmd.op = CELL_HOLD;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign load_rsp  = ((state_q == S_DONE) || (state_q == S_FIRE)) && out_free;

	// Result item
	always_comb begin
		rsp_d              = '0;
		rsp_d.time_to_next = ttn;
		if (state_q == S_FIRE) begin
			rsp_d.fired        = 1'b1;
			rsp_d.fired_target = ID_W'(fire_tgt_q);
			rsp_d.fired_cookie = fire_ck_q;
			rsp_d.last         = !head_ready;
		end else begin
			rsp_d.dropped_full = drop_q;
			rsp_d.last         = 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			time_q  <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						drop_q <= 1'b0;
						priority if (req.opcode == OP_TICK) begin
							time_q  <= time_q + TIME_W'(1);
							state_q <= S_HEAD;
						end else if (req.opcode == OP_REQUEST) begin
							state_q <= S_INS;
						end else begin
							state_q <= S_MARK;
						end
					end
				end
				S_INS: begin
					drop_q  <= full;
					state_q <= S_DONE;
				end
				S_MARK: state_q <= S_PACK;
				S_PACK: begin
					if (!any_gap) state_q <= S_DONE;
				end
				S_HEAD: state_q <= head_ready ? S_FIRE : S_DONE;
				S_FIRE: begin
					if (out_free) state_q <= head_ready ? S_HEAD : S_IDLE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item operands and popped head
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			tgt_q <= TARGET_BITS'(req.target_id);
			ck_q  <= req.cookie;
			due_q <= time_q + TIME_W'(req.timeout_ticks);
		end
		if ((state_q == S_HEAD) && head_ready) begin
			fire_tgt_q <= cell_tgt[0];
			fire_ck_q  <= cell_ent[0].cookie;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Table is packed towards the head between items
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0))
		else $error("timer table has a hole between items");

	// Head is never later than its successor
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && cell_ent[1].valid) |-> (cell_ent[0].due <= cell_ent[1].due))
		else $error("timer table out of order at the head");

	// A tick advances time by exactly one
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.opcode == OP_TICK)) |=> (time_q == $past(time_q) + TIME_W'(1)))
		else $error("tick did not advance time by one");

	// A fired result never reports a dropped request
	a_fire_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.fired) |-> !rsp.dropped_full)
		else $error("fired result flagged as dropped");

endmodule

### design/stq_cell.sv
// One cell of the timer chain: holds a single entry and trades it with its neighbours.
// Depends on stq_pkg.
module stq_cell import stq_pkg::*; #(
	parameter int TARGET_BITS = TARGET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_cmd_t              cmd,
	input  logic [TARGET_BITS-1:0] cmd_tgt,
	input  entry_t                 left_ent,
	input  logic [TARGET_BITS-1:0] left_tgt,
	input  logic                   left_keep,
	input  logic                   left_hole,
	input  entry_t                 right_ent,
	input  logic [TARGET_BITS-1:0] right_tgt,
	output entry_t                 ent,
	output logic [TARGET_BITS-1:0] tgt,
	output logic                   keep,
	output logic                   hole,
	output logic                   gap
);

	logic                   valid_q;
	logic [TIME_W-1:0]      due_q;
	logic [WORD_W-1:0]      cookie_q;
	logic [TARGET_BITS-1:0] tgt_q;
	entry_t                 ent_d;
	logic [TARGET_BITS-1:0] tgt_d;
	logic                   hit;

	assign ent = '{valid: valid_q, due: due_q, cookie: cookie_q};
	assign tgt = tgt_q;

	// Neighbour status: keep = stays put on insert, hole = empty here or earlier
	always_comb begin
		keep = valid_q && (due_q <= cmd.due);
		hole = !valid_q || left_hole;
		gap  = valid_q && left_hole;
		hit  = valid_q && (tgt_q == cmd_tgt) && (cmd.match_all || (cookie_q == cmd.cookie));
	end

	// Next contents
	always_comb begin
		ent_d = ent;
		tgt_d = tgt_q;
		unique case (cmd.op)
			CELL_HOLD: begin
			end
			CELL_INSERT: begin
				if (!keep) begin
					if (left_keep) begin
						ent_d = '{valid: 1'b1, due: cmd.due, cookie: cmd.cookie};
						tgt_d = cmd_tgt;
					end else begin
						ent_d = left_ent;
						tgt_d = left_tgt;
					end
				end
			end
			CELL_MARK: begin
				if (hit) ent_d.valid = 1'b0;
			end
			CELL_SHIFT: begin
				if (hole) begin
					ent_d = right_ent;
					tgt_d = right_tgt;
				end
			end
			CELL_POP: begin
				ent_d = right_ent;
				tgt_d = right_tgt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	// Entry payload, undefined until written
	always_ff @(posedge clk) begin
		due_q    <= ent_d.due;
		cookie_q <= ent_d.cookie;
		tgt_q    <= tgt_d;
	end

endmodule

### tb/sorted_timer_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_timer_queue_unit: directed and random timer traffic.
// Depends on stq_pkg and the design files; a behavioural timer table predicts every result.
module sorted_timer_queue_unit_tb;
	import stq_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 8;
	localparam int MAX_IDLE       = 11;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 400;
	localparam int STRETCH_ITEMS  = 40;
	localparam int STALL_ITEMS    = 36;
	localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << TARGET_BITS_DEF) - 1);

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Predicted timer table
	logic [TIME_W-1:0] model_time;
	logic [TIME_W-1:0] model_due    [QUEUE_DEPTH_DEF];
	logic [ID_W-1:0]   model_target [QUEUE_DEPTH_DEF];
	logic [WORD_W-1:0] model_cookie [QUEUE_DEPTH_DEF];
	int                model_count;
	rsp_t              pending_results[$];

	int          errors;
	int unsigned quiet_cycles;
	bit          req_no_idle;
	bit          rsp_no_stall;
	bit          hold_output;

	sorted_timer_queue_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Ticks until the head timer is due, saturated; all ones when empty
	function automatic logic [WORD_W-1:0] ticks_to_head();
		logic [TIME_W-1:0] gap;
		if (model_count == 0)
			return '1;
		if (model_due[0] <= model_time)
			return '0;
		gap = model_due[0] - model_time;
		if (gap[TIME_W-1:WORD_W] != '0)
			return '1;
		return gap[WORD_W-1:0];
	endfunction

	function automatic void push_expected(logic fired, logic [ID_W-1:0] tgt,
			logic [WORD_W-1:0] ck, logic dropped);
		rsp_t r;
		r.fired        = fired;
		r.fired_target = tgt;
		r.fired_cookie = ck;
		r.time_to_next = ticks_to_head();
		r.dropped_full = dropped;
		r.last         = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Close the gap left by one removed timer
	function automatic void remove_timer(int idx);
		for (int j = idx; j + 1 < model_count; j++) begin
			model_due[j]    = model_due[j + 1];
			model_target[j] = model_target[j + 1];
			model_cookie[j] = model_cookie[j + 1];
		end
		model_count--;
	endfunction

	// Update the table for one accepted item and queue the results it causes
	function automatic void apply_timer_item(req_t item);
		logic [ID_W-1:0]   tgt;
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   head_tgt;
		logic [WORD_W-1:0] head_ck;
		rsp_t              tail;
		bit                fired_any;
		bit                cookie_too;
		int                pos;
		int                i;
		tgt = item.target_id & ID_MASK;
		case (item.opcode)
			OP_TICK: begin
				model_time = model_time + 1'b1;
				fired_any  = 1'b0;
				while (model_count > 0 && model_due[0] <= model_time) begin
					head_tgt = model_target[0];
					head_ck  = model_cookie[0];
					remove_timer(0);
					push_expected(1'b1, head_tgt, head_ck, 1'b0);
					fired_any = 1'b1;
				end
				if (!fired_any)
					push_expected(1'b0, '0, '0, 1'b0);
			end
			OP_REQUEST: begin
				if (model_count >= QUEUE_DEPTH_DEF) begin
					push_expected(1'b0, '0, '0, 1'b1);
				end else begin
					due = model_time + item.timeout_ticks;
					pos = 0;
					while (pos < model_count && model_due[pos] <= due)
						pos++;
					for (int j = model_count; j > pos; j--) begin
						model_due[j]    = model_due[j - 1];
						model_target[j] = model_target[j - 1];
						model_cookie[j] = model_cookie[j - 1];
					end
					model_due[pos]    = due;
					model_target[pos] = tgt;
					model_cookie[pos] = item.cookie;
					model_count++;
					push_expected(1'b0, '0, '0, 1'b0);
				end
			end
			default: begin
				// kill matches target and cookie, kill-all the target alone
				cookie_too = (item.opcode == OP_KILL);
				i = 0;
				while (i < model_count) begin
					if (model_target[i] == tgt && (!cookie_too || model_cookie[i] == item.cookie))
						remove_timer(i);
					else
						i++;
				end
				push_expected(1'b0, '0, '0, 1'b0);
			end
		endcase
		tail      = pending_results.pop_back();
		tail.last = 1'b1;
		pending_results.push_back(tail);
	endfunction

	// Predict on input acceptance, then check any result taken at the same edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				apply_timer_item(req);
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: fired=%0b target=%h cookie=%h next=%h drop=%0b last=%0b",
						$time, rsp.fired, rsp.fired_target, rsp.fired_cookie,
						rsp.time_to_next, rsp.dropped_full, rsp.last);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (rsp !== want) begin
						errors++;
						$display("%0t: result mismatch: expected fired=%0b target=%h cookie=%h next=%h drop=%0b last=%0b",
							$time, want.fired, want.fired_target, want.fired_cookie,
							want.time_to_next, want.dropped_full, want.last);
						$display("%0t:                  actual   fired=%0b target=%h cookie=%h next=%h drop=%0b last=%0b",
							$time, rsp.fired, rsp.fired_target, rsp.fired_cookie,
							rsp.time_to_next, rsp.dropped_full, rsp.last);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stall before each item, one long hold when asked
	initial begin
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				stall       = HOLD_CYCLES;
				hold_output = 1'b0;
			end else begin
				stall = rsp_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	function automatic req_t timer_item(logic [1:0] op, logic [ID_W-1:0] tgt,
			logic [WORD_W-1:0] tmo, logic [WORD_W-1:0] ck);
		req_t item;
		item.opcode        = op;
		item.target_id     = tgt;
		item.timeout_ticks = tmo;
		item.cookie        = ck;
		return item;
	endfunction

	// Offer one item and hold it until it is taken
	task automatic send_item(input req_t item);
		int gap;
		gap = req_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Random item; filling favours requests, draining favours ticks and kills
	function automatic req_t random_timer_item(bit filling);
		req_t item;
		int   r;
		int   pick;
		item.target_id = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 7))
			: ID_W'($urandom);
		item.cookie = ($urandom_range(0, 9) < 7) ? WORD_W'($urandom_range(0, 3)) : $urandom;
		r = $urandom_range(0, 19);
		if (r < 12)
			item.timeout_ticks = $urandom_range(0, 15);
		else if (r < 17)
			item.timeout_ticks = $urandom_range(16, 300);
		else
			item.timeout_ticks = $urandom;
		r = $urandom_range(0, 99);
		if (filling)
			item.opcode = (r < 25) ? OP_TICK : (r < 85) ? OP_REQUEST
				: (r < 95) ? OP_KILL : OP_KILL_ALL;
		else
			item.opcode = (r < 55) ? OP_TICK : (r < 70) ? OP_REQUEST
				: (r < 85) ? OP_KILL : OP_KILL_ALL;
		// most kills aim at a live timer
		if ((item.opcode == OP_KILL || item.opcode == OP_KILL_ALL) && model_count > 0
				&& $urandom_range(0, 9) < 6) begin
			pick           = $urandom_range(0, model_count - 1);
			item.target_id = model_target[pick];
			item.cookie    = model_cookie[pick];
		end
		return item;
	endfunction

	task automatic test_empty_table();
		send_item(timer_item(OP_TICK, '1, '1, '1));
	endtask

	task automatic test_basic_timers();
		send_item(timer_item(OP_REQUEST, 8'hFF, '0, 32'hFFFF_FFFF));
		send_item(timer_item(OP_REQUEST, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000));
		send_item(timer_item(OP_REQUEST, 8'hA5, 32'd2, 32'h5A5A_5A5A));
		send_item(timer_item(OP_TICK, '0, '0, '0));
		send_item(timer_item(OP_KILL, 8'hA5, '0, 32'h0000_0001));
		send_item(timer_item(OP_KILL, 8'hA5, '0, 32'h5A5A_5A5A));
		send_item(timer_item(OP_TICK, '0, '0, '0));
		send_item(timer_item(OP_KILL_ALL, 8'h00, '0, 32'hDEAD_BEEF));
	endtask

	// Equal due times fire in insertion order; one request past full is dropped
	task automatic test_full_table();
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
			send_item(timer_item(OP_REQUEST, ID_W'(i % 4), 32'd1, WORD_W'(i)));
		send_item(timer_item(OP_REQUEST, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(timer_item(OP_TICK, '0, '0, '0));
	endtask

	// Result side held off while items keep coming, so the input stalls
	task automatic test_output_stall();
		req_no_idle = 1'b1;
		hold_output = 1'b1;
		for (int k = 0; k < STALL_ITEMS; k++)
			send_item(random_timer_item(1'b1));
		req_no_idle = 1'b0;
	endtask

	task automatic test_random_traffic();
		bit filling;
		int mode;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % STRETCH_ITEMS == 0) begin
				filling      = 1'($urandom_range(0, 1));
				mode         = $urandom_range(0, 3);
				req_no_idle  = (mode == 1) || (mode == 3);
				rsp_no_stall = (mode == 2) || (mode == 3);
			end
			send_item(random_timer_item(filling));
		end
		req_no_idle  = 1'b0;
		rsp_no_stall = 1'b0;
	endtask

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		req_no_idle  = 1'b0;
		rsp_no_stall = 1'b0;
		hold_output  = 1'b0;
		model_time   = '0;
		model_count  = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_basic_timers();
		test_full_table();
		test_output_stall();
		test_random_traffic();
		req_valid <= 1'b0;

		// let every outstanding result arrive, then watch for strays
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
